@@ src/base64_stream_codec_unit_assert.svh @@
// Assertion macros used by the codec top level.
`ifndef BASE64_STREAM_CODEC_UNIT_ASSERT_SVH
`define BASE64_STREAM_CODEC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define B64SC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64sc: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define B64SC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64sc: next-cycle check failed");

`endif

@@ src/b64sc_pkg.sv @@
package b64sc_pkg;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_D0    = 8'h30;  // '0'

    // Decoded character value: 0..63 digit, pad, or not in the alphabet
    localparam logic [6:0] VAL_PAD = 7'd64;
    localparam logic [6:0] VAL_BAD = 7'd65;

    // A burst of up to four result words handed to the output stage
    typedef struct packed {
        logic            load;
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            last;
        logic            bad;
    } burst_t;

    // Output stage occupancy
    typedef struct packed {
        logic busy;
        logic one_left;
    } emit_status_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] sym_of(input logic [5:0] v);
        logic [7:0] r;
        case (v) inside
            [6'd0:6'd25]:  r = CHAR_UA + {2'b00, v};
            [6'd26:6'd51]: r = CHAR_LA + ({2'b00, v} - 8'd26);
            [6'd52:6'd61]: r = CHAR_D0 + ({2'b00, v} - 8'd52);
            6'd62:         r = CHAR_PLUS;
            default:       r = CHAR_SLASH;
        endcase
        return r;
    endfunction

    // Alphabet character to value
    function automatic logic [6:0] val_of(input logic [7:0] c);
        logic [6:0] r;
        case (c) inside
            ["A":"Z"]:  r = 7'(c - CHAR_UA);
            ["a":"z"]:  r = 7'(c - CHAR_LA + 8'd26);
            ["0":"9"]:  r = 7'(c - CHAR_D0 + 8'd52);
            CHAR_PLUS:  r = 7'd62;
            CHAR_SLASH: r = 7'd63;
            CHAR_PAD:   r = VAL_PAD;
            default:    r = VAL_BAD;
        endcase
        return r;
    endfunction

endpackage

@@ src/b64sc_group.sv @@
module b64sc_group
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_mode,
    input  logic       accept,
    input  logic [7:0] data_in,
    input  logic       last_in,
    output burst_t     burst
);

    logic        mode_reg;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  pad_reg, pad_next;
    logic        bad_reg, bad_next;

    // Per-word group update and burst build
    always_comb
    begin
        logic [23:0] ob;
        logic [2:0]  chars;
        logic [6:0]  v;
        logic [5:0]  dv;
        logic [1:0]  pads;
        logic [1:0]  missing;
        logic [23:0] sb;
        logic [2:0]  tp;
        logic        close;

        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        bad_next  = bad_reg;
        burst     = '0;
        ob        = bits_reg;
        chars     = 3'd0;
        v         = 7'd0;
        dv        = 6'd0;
        pads      = pad_reg;
        missing   = 2'd0;
        sb        = bits_reg;
        tp        = 3'd0;
        close     = 1'b0;

        if (mode_reg)
        begin
            // encode: place byte in the group, emit four chars on close
            case (cnt_reg)
                2'd0:    ob = bits_reg | {data_in, 16'h0000};
                2'd1:    ob = bits_reg | {8'h00, data_in, 8'h00};
                2'd2:    ob = bits_reg | {16'h0000, data_in};
                default: ob = bits_reg;
            endcase
            close = (cnt_reg == 2'd2) || last_in;
            chars = {1'b0, cnt_reg} + 3'd2;
            for (int k = 0; k < 4; k++)
            begin
                burst.bytes[k] = (3'(k) < chars) ? sym_of(ob[23 - 6 * k -: 6]) : CHAR_PAD;
            end
            burst.count = close ? 3'd4 : 3'd0;
            if (close)
            begin
                bits_next = '0;
                cnt_next  = '0;
                pad_next  = '0;
                bad_next  = 1'b0;
            end
            else
            begin
                bits_next = ob;
                cnt_next  = cnt_reg + 2'd1;
            end
        end
        else
        begin
            // decode: shift in six bits, emit up to three bytes on close
            v = val_of(data_in);
            burst.bad = bad_reg;
            if (v == VAL_PAD)
            begin
                dv = 6'd0;
                if (pads != 2'd3)
                    pads = pads + 2'd1;
            end
            else if (v == VAL_BAD)
            begin
                dv = 6'd0;
                burst.bad = 1'b1;
            end
            else
            begin
                dv = v[5:0];
            end
            ob      = {bits_reg[17:0], dv};
            close   = (cnt_reg == 2'd3) || last_in;
            missing = 2'd3 - cnt_reg;
            case (missing)
                2'd0:    sb = ob;
                2'd1:    sb = {ob[17:0], 6'd0};
                2'd2:    sb = {ob[11:0], 12'd0};
                default: sb = {ob[5:0], 18'd0};
            endcase
            tp = {1'b0, pads} + {1'b0, missing};
            if (tp > 3'd3)
                tp = 3'd3;
            burst.bytes[0] = sb[23:16];
            burst.bytes[1] = sb[15:8];
            burst.bytes[2] = sb[7:0];
            burst.bytes[3] = 8'h00;
            burst.count    = close ? (3'd3 - tp) : 3'd0;
            if (close)
            begin
                bits_next = '0;
                cnt_next  = '0;
                pad_next  = '0;
                bad_next  = 1'b0;
            end
            else
            begin
                bits_next = ob;
                cnt_next  = cnt_reg + 2'd1;
                pad_next  = pads;
                bad_next  = burst.bad;
            end
        end

        burst.last = last_in;
        burst.load = accept && (burst.count != 3'd0);
    end

    // Mode and group state; a mode write clears the group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
            bits_reg <= '0;
            cnt_reg  <= '0;
            pad_reg  <= '0;
            bad_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_mode;
            bits_reg <= '0;
            cnt_reg  <= '0;
            pad_reg  <= '0;
            bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            pad_reg  <= pad_next;
            bad_reg  <= bad_next;
        end
    end

endmodule

@@ src/b64sc_emit.sv @@
module b64sc_emit
    import b64sc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  burst_t       burst,
    output emit_status_t status,
    output logic         load_ok,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   data_out,
    output logic         last_out,
    output logic         bad_char
);

    logic [2:0]      cnt_reg, cnt_next;
    logic [3:0][7:0] data_reg, data_next;
    logic            last_reg, last_next;
    logic            bad_reg, bad_next;

    assign status.busy     = (cnt_reg != 3'd0);
    assign status.one_left = (cnt_reg == 3'd1);
    assign load_ok         = !status.busy || (status.one_left && out_ready);

    assign out_valid = status.busy;
    assign data_out  = data_reg[0];
    assign last_out  = last_reg && status.one_left;
    assign bad_char  = bad_reg;

    // Load a burst or shift out one word
    always_comb
    begin
        cnt_next  = cnt_reg;
        data_next = data_reg;
        last_next = last_reg;
        bad_next  = bad_reg;
        if (burst.load)
        begin
            cnt_next  = burst.count;
            data_next = burst.bytes;
            last_next = burst.last;
            bad_next  = burst.bad;
        end
        else if (out_valid && out_ready)
        begin
            cnt_next  = cnt_reg - 3'd1;
            data_next = data_reg >> 8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

endmodule

@@ src/base64_stream_codec_unit.sv @@
// Channel | Handshake                | Payload
// cfg     | cfg_valid / cfg_ready    | cfg_data (1 = encode, 0 = decode)
// in      | in_valid / in_ready      | data_in[7:0], last_in
// out     | out_valid / out_ready    | data_out[7:0], last_out, bad_char
//
// A group closing input word loads a burst of up to four result words into
// the output register, which then drains one word a cycle while out_ready
// is high.
// in_ready is high while the output register is empty or its last word is
// leaving in the same cycle.
// Reset sets encode mode and clears the group; a mode write also clears it.
// cfg_ready is always high.
`include "base64_stream_codec_unit_assert.svh"

module base64_stream_codec_unit
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_in,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_out,
    output logic       last_out,
    output logic       bad_char
);

    burst_t       burst;
    emit_status_t status;
    logic         load_ok;
    logic         accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = load_ok;
    assign accept    = in_valid && in_ready;

    // Group gathering and burst build
    b64sc_group u_group (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_mode (cfg_data),
        .accept   (accept),
        .data_in  (data_in),
        .last_in  (last_in),
        .burst    (burst)
    );

    // Result register and serializer
    b64sc_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .burst     (burst),
        .status    (status),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .last_out  (last_out),
        .bad_char  (bad_char)
    );

    // A burst is only loaded when the output register frees up
    `B64SC_ASSERT_IMPLY(a_load_free, clk, rst_n, burst.load,
        !status.busy || (status.one_left && out_ready))
    // The last flag only rides on the final word of a burst
    `B64SC_ASSERT_IMPLY(a_last_final, clk, rst_n, out_valid && last_out, status.one_left)
    // Draining the final word with no new burst empties the output
    `B64SC_ASSERT_NEXT(a_drain_empty, clk, rst_n,
        status.one_left && out_ready && !burst.load, !out_valid)

endmodule

@@ dv/base64_stream_codec_checker.sv @@
`timescale 1ns / 100ps

module base64_stream_codec_checker
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_in,
    input  logic       last_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] data_out,
    input  logic       last_out,
    input  logic       bad_char,
    output int         mismatch_count,
    output int         pending,
    output int         results_checked,
    output int         bad_results
);

    // One output word as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } codec_word_t;

    codec_word_t words_due[$];

    // Shadow of the block's mode and group state
    logic        encoding;
    logic [23:0] grp_bits;
    logic [1:0]  grp_cnt;
    logic [1:0]  grp_pads;
    logic        grp_bad;

    // 6-bit digit to alphabet character
    function automatic logic [7:0] digit_to_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26)
            return CHAR_UA + w;
        if (w < 8'd52)
            return CHAR_LA + w - 8'd26;
        if (w < 8'd62)
            return CHAR_D0 + w - 8'd52;
        return (w == 8'd62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // Character to digit value, pad marker or bad marker
    function automatic logic [6:0] char_to_digit(input logic [7:0] c);
        if (c >= CHAR_UA && c <= CHAR_UA + 8'd25)
            return 7'(c - CHAR_UA);
        if (c >= CHAR_LA && c <= CHAR_LA + 8'd25)
            return 7'(c - CHAR_LA + 8'd26);
        if (c >= CHAR_D0 && c <= CHAR_D0 + 8'd9)
            return 7'(c - CHAR_D0 + 8'd52);
        if (c == CHAR_PLUS)
            return 7'd62;
        if (c == CHAR_SLASH)
            return 7'd63;
        if (c == CHAR_PAD)
            return VAL_PAD;
        return VAL_BAD;
    endfunction

    task automatic clear_group();
        grp_bits = '0;
        grp_cnt  = '0;
        grp_pads = '0;
        grp_bad  = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("%0t ns: %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    endtask

    // Fold one accepted input word into the group; queue the words it releases
    task automatic predict_codec_words(input logic [7:0] d, input logic l);
        codec_word_t w;
        logic [23:0] bits;
        logic [6:0]  v;
        int          cnt;
        int          pads;
        int          missing;
        int          n;
        cnt = grp_cnt;
        if (encoding) begin
            grp_bits = grp_bits | (24'(d) << (16 - 8 * cnt));
            cnt++;
            if (cnt == 3 || l) begin
                // cnt + 1 characters, then pad up to four
                for (int k = 0; k < 4; k++) begin
                    w.data = (k <= cnt) ? digit_to_char(grp_bits[23 - 6 * k -: 6]) : CHAR_PAD;
                    w.last = l && (k == 3);
                    w.bad  = 1'b0;
                    words_due.push_back(w);
                end
                clear_group();
            end
            else begin
                grp_cnt = 2'(cnt);
            end
        end
        else begin
            v    = char_to_digit(d);
            pads = grp_pads;
            if (v == VAL_PAD) begin
                v = '0;
                if (pads < 3)
                    pads++;
            end
            else if (v == VAL_BAD) begin
                v       = '0;
                grp_bad = 1'b1;
            end
            grp_bits = {grp_bits[17:0], v[5:0]};
            cnt++;
            if (cnt == 4 || l) begin
                // a short group at the end counts its missing chars as pads
                missing = 4 - cnt;
                bits    = grp_bits << (6 * missing);
                n       = 3 - ((pads + missing > 3) ? 3 : pads + missing);
                for (int k = 0; k < n; k++) begin
                    w.data = bits[23 - 8 * k -: 8];
                    w.last = l && (k == n - 1);
                    w.bad  = grp_bad;
                    words_due.push_back(w);
                end
                clear_group();
            end
            else begin
                grp_cnt  = 2'(cnt);
                grp_pads = 2'(pads);
            end
        end
    endtask

    // Compare output words, then track mode writes and input words
    always @(posedge clk or negedge rst_n) begin
        codec_word_t want;
        if (!rst_n) begin
            words_due.delete();
            encoding = 1'b1;
            clear_group();
            pending = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                results_checked++;
                if (bad_char === 1'b1)
                    bad_results++;
                if (words_due.size() == 0) begin
                    report_mismatch("output word with nothing expected", data_out, 8'h00);
                end
                else begin
                    want = words_due.pop_front();
                    if (data_out !== want.data)
                        report_mismatch("data_out", data_out, want.data);
                    if (last_out !== want.last)
                        report_mismatch("last_out", {7'd0, last_out}, {7'd0, want.last});
                    if (bad_char !== want.bad)
                        report_mismatch("bad_char", {7'd0, bad_char}, {7'd0, want.bad});
                end
            end
            if (cfg_valid && cfg_ready) begin
                encoding = cfg_data;
                clear_group();
            end
            if (in_valid && in_ready)
                predict_codec_words(data_in, last_in);
            pending = words_due.size();
        end
    end

endmodule

@@ dv/base64_stream_codec_unit_tb.sv @@
`timescale 1ns / 100ps

module base64_stream_codec_unit_tb
    import b64sc_pkg::*;
();

    localparam int RANDOM_WORDS = 405;
    localparam int QUIET_WORDS  = 60;
    localparam int RUN_LIMIT_NS = 4_000_000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_in;
    logic       last_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] data_out;
    logic       last_out;
    logic       bad_char;

    int mismatch_count;
    int pending;
    int results_checked;
    int bad_results;

    // Stimulus state
    bit    gaps_on;
    bit    stalls_on;
    logic  encoding_now;
    int    words_sent;
    int    directed_words;
    int    mode_writes;
    string alphabet_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    base64_stream_codec_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_in   (data_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .last_out  (last_out),
        .bad_char  (bad_char)
    );

    base64_stream_codec_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_in         (data_in),
        .last_in         (last_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_out        (data_out),
        .last_out        (last_out),
        .bad_char        (bad_char),
        .mismatch_count  (mismatch_count),
        .pending         (pending),
        .results_checked (results_checked),
        .bad_results     (bad_results)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output back-pressure in random bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] random_alpha();
        return alphabet_chars[$urandom_range(0, 63)];
    endfunction

    // Present one input word, optionally after an idle burst; returns on a falling edge
    task automatic send_word(input logic [7:0] d, input logic l);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_in  <= d;
        last_in  <= l;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        words_sent++;
    endtask

    // Hold the sender off until every queued result word has come out
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Mode write while idle; any partial group is dropped by it
    task automatic write_mode(input logic m);
        wait_for_results();
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid    <= 1'b0;
        encoding_now = m;
        mode_writes++;
    endtask

    // Raw bytes of random length; an open message keeps its group running
    task automatic send_byte_message(input bit closed);
        int len;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom_range(0, 255)), closed && (i == len - 1));
    endtask

    // Mostly well-formed base64 text, some noise with junk and stray pads
    task automatic send_text_message();
        int         len;
        logic [7:0] ch;
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 2))
                    0:       ch = 8'($urandom_range(0, 255));
                    1:       ch = CHAR_PAD;
                    default: ch = random_alpha();
                endcase
                send_word(ch, (i == len - 1) && ($urandom_range(0, 1) == 1));
            end
            return;
        end
        repeat (4 * $urandom_range(0, 3)) send_word(random_alpha(), 1'b0);
        case ($urandom_range(0, 3))
            0:
            begin
                for (int i = 0; i < 4; i++)
                    send_word(random_alpha(), i == 3);
            end
            1:
            begin
                repeat (2) send_word(random_alpha(), 1'b0);
                send_word(CHAR_PAD, 1'b0);
                send_word(CHAR_PAD, 1'b1);
            end
            2:
            begin
                repeat (3) send_word(random_alpha(), 1'b0);
                send_word(CHAR_PAD, 1'b1);
            end
            default:
            begin
                // unpadded tail of two or three chars
                len = $urandom_range(2, 3);
                for (int i = 0; i < len; i++)
                    send_word(random_alpha(), i == len - 1);
            end
        endcase
    endtask

    initial
    begin
        int  phase;
        bit  quiet;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        in_valid     = 1'b0;
        data_in      = '0;
        last_in      = 1'b0;
        gaps_on      = 1'b0;
        stalls_on    = 1'b0;
        encoding_now = 1'b1;
        words_sent   = 0;
        mode_writes  = 0;
        phase        = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Encode after reset: full group, one and two byte tails, last on a full group
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hFB, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'h02, 1'b0);
        send_word(8'h03, 1'b1);
        // open group, then a mode change drops it
        send_word(8'h5A, 1'b0);
        write_mode(1'b0);

        // Decode: full group, junk char with a pad in mid group, three pads,
        // unpadded three-char and one-char tails
        send_word("z", 1'b0);
        send_word("9", 1'b0);
        send_word(CHAR_PLUS, 1'b0);
        send_word(CHAR_SLASH, 1'b0);
        send_word("A", 1'b0);
        send_word("*", 1'b0);
        send_word(CHAR_PAD, 1'b0);
        send_word("B", 1'b0);
        send_word("A", 1'b0);
        send_word(CHAR_PAD, 1'b0);
        send_word(CHAR_PAD, 1'b0);
        send_word(CHAR_PAD, 1'b0);
        send_word("Q", 1'b0);
        send_word("U", 1'b0);
        send_word("I", 1'b1);
        send_word("Q", 1'b1);
        directed_words = words_sent;

        // Random phases, each under one mode; the tail runs without idling
        while (words_sent < directed_words + RANDOM_WORDS)
        begin
            phase++;
            quiet     = words_sent >= directed_words + RANDOM_WORDS - QUIET_WORDS;
            gaps_on   = !quiet && ($urandom_range(0, 3) != 0);
            stalls_on = !quiet && ($urandom_range(0, 3) != 0);
            // mostly flip the mode, sometimes rewrite the same value
            write_mode((phase % 3 == 2) ? encoding_now : !encoding_now);
            repeat ($urandom_range(3, 8))
            begin
                if (words_sent >= directed_words + RANDOM_WORDS)
                    break;
                // entering the tail turns idling off mid phase
                if (words_sent >= directed_words + RANDOM_WORDS - QUIET_WORDS)
                begin
                    quiet     = 1'b1;
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end
                if (encoding_now)
                    send_byte_message($urandom_range(0, 7) != 0);
                else
                    send_text_message();
                if (!quiet && $urandom_range(0, 11) == 0)
                    wait_for_results();
            end
        end

        // Drain and settle
        wait_for_results();
        repeat (20) @(negedge clk);
        $display("Drove %0d input words (%0d directed) across %0d mode writes.",
                 words_sent, directed_words, mode_writes);
        $display("Checked %0d output words, %0d of them with bad_char set.",
                 results_checked, bad_results);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/b64sc_pkg.sv
src/b64sc_group.sv
src/b64sc_emit.sv
src/base64_stream_codec_unit.sv
dv/base64_stream_codec_checker.sv
dv/base64_stream_codec_unit_tb.sv
